FILE: rtl/core/irbe_pkg.sv
// ----------------------------------------------------------------------------
// IR bearing estimator package
// Shared types, constants, the bearing table and small helper functions.
// ----------------------------------------------------------------------------
package irbe_pkg;

    localparam int SENSOR_COUNT = 6;
    localparam int CFG_ADDR_W   = 4;

    typedef logic signed [8:0] t_deg;
    typedef logic [2:0]        t_sensor;
    typedef logic [1:0]        t_reg_idx;

    localparam t_sensor    NONE_SENSOR  = 3'd7;
    localparam logic [5:0] FRONT_MASK   = 6'b100011;
    localparam logic [7:0] STABLE_MAX   = 8'hFF;
    localparam t_deg       BEARING_LOST = -9'sd1;

    // Register indexes, at byte address 4 * index.
    localparam t_reg_idx REG_ACTIVE_LEVEL     = 2'd0;
    localparam t_reg_idx REG_STABLE_THRESHOLD = 2'd1;
    localparam t_reg_idx REG_LOST_HOLD_MS     = 2'd2;
    localparam t_reg_idx REG_REPORT_INTERVAL  = 2'd3;

    localparam logic        RST_ACTIVE_LEVEL     = 1'b0;
    localparam logic [7:0]  RST_STABLE_THRESHOLD = 8'd2;
    localparam logic [15:0] RST_LOST_HOLD_MS     = 16'd120;
    localparam logic [15:0] RST_REPORT_INTERVAL  = 16'd150;

    // Rounded bearing, indexed by row * 9 + nx * 3 + ny, where row is
    // s1 + 2*s4, nx is s0 - s5 + 1 and ny is s2 - s3 + 1.
    localparam t_deg BEARING_TAB [36] = '{
        -9'sd141,  9'sd180,  9'sd141, -9'sd90,   9'sd0,   9'sd90,
        -9'sd39,   9'sd0,    9'sd39,
        -9'sd114,  9'sd105,  9'sd96,  -9'sd19,   9'sd30,  9'sd56,
        -9'sd9,    9'sd15,   9'sd35,
        -9'sd104, -9'sd128,  9'sd128, -9'sd60,  -9'sd30,  9'sd30,
        -9'sd35,  -9'sd13,   9'sd13,
        -9'sd51,   9'sd10,   9'sd58,  -9'sd24,   9'sd4,   9'sd30,
        -9'sd15,   9'sd2,    9'sd19
    };

    typedef struct packed {
        logic       act_any;
        t_sensor    main_idx;
        logic [2:0] total;
        t_deg       bearing;
    } t_merge;

    typedef struct packed {
        logic emit;
        logic lost;
        logic report;
    } t_track;

    typedef struct packed {
        t_deg       bearing_deg;
        logic       lost;
        t_sensor    main_sensor;
        logic [2:0] active_total;
        logic       report;
    } t_result;

    function automatic logic [2:0] popcount6(input logic [5:0] v);
        logic [2:0] c;
        c = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            c = c + {2'b00, v[k]};
        end
        return c;
    endfunction

    function automatic t_deg bearing_of(input logic [5:0] act);
        logic [1:0] row;
        logic [1:0] nx;
        logic [1:0] ny;
        logic [5:0] idx;
        row = {act[4], act[1]};
        nx  = {act[0] & ~act[5], act[0] ~^ act[5]};
        ny  = {act[2] & ~act[3], act[2] ~^ act[3]};
        idx = ({4'd0, row} << 3) + {4'd0, row} + ({4'd0, nx} << 1) + {4'd0, nx}
            + {4'd0, ny};
        return BEARING_TAB[idx];
    endfunction

endpackage

FILE: rtl/core/irbe_in_if.sv
// ----------------------------------------------------------------------------
// IR bearing estimator sample channel
// Valid/ready channel that carries one sensor sample per beat.
// ----------------------------------------------------------------------------
interface irbe_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  sensor_levels;
    logic [31:0] now_ms;

    modport source (output valid, output sensor_levels, output now_ms, input ready);
    modport sink   (input valid, input sensor_levels, input now_ms, output ready);
endinterface

FILE: rtl/core/irbe_out_if.sv
// ----------------------------------------------------------------------------
// IR bearing estimator result channel
// Valid/ready channel that carries one drive or lost result per beat.
// ----------------------------------------------------------------------------
interface irbe_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] bearing_deg;
    logic              lost;
    logic [2:0]        main_sensor;
    logic [2:0]        active_total;
    logic              report;

    modport source (output valid, output bearing_deg, output lost, output main_sensor,
                    output active_total, output report, input ready);
    modport sink   (input valid, input bearing_deg, input lost, input main_sensor,
                    input active_total, input report, output ready);
endinterface

FILE: rtl/core/ir_bearing_estimator_debounced_unit.sv
// ----------------------------------------------------------------------------
// IR bearing estimator with direction debouncing
// Six sensor lanes, a merge stage, a tracking stage and an output register.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Beat contents
//  i_sample  in         valid/ready          sensor_levels, now_ms
//  o_result  out        valid/ready          bearing_deg, lost, main_sensor,
//                                            active_total, report
//  APB       in/out     psel/penable/pready  4 registers at 4*index
//
//  One sample per cycle sustained while the output is not stalled; each result is
//  registered in stage 1 and then in the output register. Stage 1 registers the
//  merged lane data; the tracker updates its state as the item leaves stage 1.
//  A stalled output holds its beat while stage 1 still takes one more sample;
//  samples that give no result drain even while the output is full.
//  Synchronous active-low reset clears control and tracking state; no clear pass.
// ----------------------------------------------------------------------------
module ir_bearing_estimator_debounced_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    irbe_in_if.sink                         i_sample,
    irbe_out_if.source                      o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [irbe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import irbe_pkg::*;

    // Configuration registers.
    logic        r_active_level;
    logic [7:0]  r_stable_threshold;
    logic [15:0] r_lost_hold_ms;
    logic [15:0] r_report_interval_ms;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level       <= RST_ACTIVE_LEVEL;
            r_stable_threshold   <= RST_STABLE_THRESHOLD;
            r_lost_hold_ms       <= RST_LOST_HOLD_MS;
            r_report_interval_ms <= RST_REPORT_INTERVAL;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ACTIVE_LEVEL:     r_active_level       <= pwdata[0];
                REG_STABLE_THRESHOLD: r_stable_threshold   <= pwdata[7:0];
                REG_LOST_HOLD_MS:     r_lost_hold_ms       <= pwdata[15:0];
                REG_REPORT_INTERVAL:  r_report_interval_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LEVEL:     prdata = {31'd0, r_active_level};
            REG_STABLE_THRESHOLD: prdata = {24'd0, r_stable_threshold};
            REG_LOST_HOLD_MS:     prdata = {16'd0, r_lost_hold_ms};
            REG_REPORT_INTERVAL:  prdata = {16'd0, r_report_interval_ms};
            default:              prdata = '0;
        endcase
    end

    // Sensor lanes.
    logic [5:0] lane_act;
    logic [5:0] lane_kept;
    logic [5:0] lane_main;
    t_merge     merged;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        irbe_lane #(.LANE(g)) u_lane (
            .i_levels       (i_sample.sensor_levels),
            .i_active_level (r_active_level),
            .o_act          (lane_act[g]),
            .o_kept         (lane_kept[g]),
            .o_is_main      (lane_main[g])
        );
    end

    irbe_merge u_merge (
        .i_act     (lane_act),
        .i_kept    (lane_kept),
        .i_is_main (lane_main),
        .o_merge   (merged)
    );

    // Stage 1 register and output register.
    logic        r_s1_valid;
    t_merge      r_s1;
    logic [31:0] r_s1_now;
    logic        r_out_valid;
    t_result     r_out;
    t_track      track;
    logic        out_free;
    logic        s1_consume;
    logic        in_fire;

    assign out_free   = !r_out_valid || o_result.ready;
    assign s1_consume = r_s1_valid && (!track.emit || out_free);
    assign i_sample.ready = !r_s1_valid || s1_consume;
    assign in_fire    = i_sample.valid && i_sample.ready;

    irbe_track u_track (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_fire               (s1_consume),
        .i_merge              (r_s1),
        .i_now                (r_s1_now),
        .i_stable_threshold   (r_stable_threshold),
        .i_lost_hold_ms       (r_lost_hold_ms),
        .i_report_interval_ms (r_report_interval_ms),
        .o_track              (track)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1     <= merged;
            r_s1_now <= i_sample.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_consume && track.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_consume && track.emit) begin
            if (track.lost) begin
                r_out <= '{bearing_deg: BEARING_LOST, lost: 1'b1, main_sensor: '0,
                           active_total: '0, report: 1'b0};
            end else begin
                r_out <= '{bearing_deg: r_s1.bearing, lost: 1'b0,
                           main_sensor: r_s1.main_idx, active_total: r_s1.total,
                           report: track.report};
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.bearing_deg  = r_out.bearing_deg;
    assign o_result.lost         = r_out.lost;
    assign o_result.main_sensor  = r_out.main_sensor;
    assign o_result.active_total = r_out.active_total;
    assign o_result.report       = r_out.report;

`ifndef ASSERT_OFF
    // A drive result always names a real sensor and a nonempty kept list.
    a_drive_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.lost) |-> (r_out.active_total != 3'd0
            && r_out.main_sensor < 3'd6))
        else $error("drive result with empty sensor list");

    // A stage 1 item that was not consumed is still present next cycle.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_consume) |=> (r_s1_valid && $stable(r_s1_now)))
        else $error("stage 1 item lost while stalled");

    // An item with active sensors always has a nonzero kept count.
    a_s1_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.act_any) |-> (r_s1.total != 3'd0))
        else $error("active sample with no kept sensors");
`endif

endmodule

FILE: rtl/core/irbe_lane.sv
// ----------------------------------------------------------------------------
// IR bearing estimator sensor lane
// Detection, front filtering and median rank test for one sensor.
// ----------------------------------------------------------------------------
module irbe_lane #(
    parameter int LANE = 0
) (
    input  logic [5:0] i_levels,
    input  logic       i_active_level,
    output logic       o_act,
    output logic       o_kept,
    output logic       o_is_main
);
    import irbe_pkg::*;

    localparam logic [5:0] LOW_MASK = 6'((1 << LANE) - 1);

    logic [5:0] act;
    logic [5:0] front;
    logic [5:0] kept;
    logic [2:0] n_kept;
    logic [2:0] rank;

    always_comb begin
        act   = i_active_level ? i_levels : ~i_levels;
        front = act & FRONT_MASK;
        // When any front sensor sees the source, the others drop out of the list.
        kept  = (|front) ? front : act;
        n_kept = popcount6(kept);
        rank   = popcount6(kept & LOW_MASK);
    end

    assign o_act     = act[LANE];
    assign o_kept    = kept[LANE];
    assign o_is_main = kept[LANE] && (rank == (n_kept >> 1));

endmodule

FILE: rtl/core/irbe_merge.sv
// ----------------------------------------------------------------------------
// IR bearing estimator lane merge
// Combines lane flags into main sensor, kept count and table bearing.
// ----------------------------------------------------------------------------
module irbe_merge (
    input  logic [5:0]       i_act,
    input  logic [5:0]       i_kept,
    input  logic [5:0]       i_is_main,
    output irbe_pkg::t_merge o_merge
);
    import irbe_pkg::*;

    t_sensor main_idx;

    always_comb begin
        main_idx = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            if (i_is_main[k]) begin
                main_idx = main_idx | t_sensor'(k);
            end
        end
        o_merge.act_any  = |i_act;
        o_merge.main_idx = main_idx;
        o_merge.total    = popcount6(i_kept);
        o_merge.bearing  = bearing_of(i_act);
    end

endmodule

FILE: rtl/core/irbe_track.sv
// ----------------------------------------------------------------------------
// IR bearing estimator tracker
// Stability counter, report timing and lost detection state.
// ----------------------------------------------------------------------------
module irbe_track (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  irbe_pkg::t_merge i_merge,
    input  logic [31:0]      i_now,
    input  logic [7:0]       i_stable_threshold,
    input  logic [15:0]      i_lost_hold_ms,
    input  logic [15:0]      i_report_interval_ms,
    output irbe_pkg::t_track o_track
);
    import irbe_pkg::*;

    t_sensor     r_prev_main,    n_prev_main;
    t_sensor     r_stable_main,  n_stable_main;
    logic [7:0]  r_stable_count, n_stable_count;
    logic [31:0] r_last_report,  n_last_report;
    logic [31:0] r_last_signal,  n_last_signal;

    logic [31:0] dt_sig;
    logic [31:0] dt_rep;
    logic        lost_go;
    logic [7:0]  cnt_next;
    logic        drive;
    logic        rep;

    always_comb begin
        dt_sig  = i_now - r_last_signal;
        lost_go = dt_sig > {16'd0, i_lost_hold_ms};

        if (i_merge.main_idx != r_prev_main) begin
            cnt_next = 8'd1;
        end else if (r_stable_count == STABLE_MAX) begin
            cnt_next = r_stable_count;
        end else begin
            cnt_next = r_stable_count + 8'd1;
        end
        drive = cnt_next >= i_stable_threshold;

        dt_rep = i_now - r_last_report;
        rep    = (i_merge.main_idx != r_stable_main)
              || (dt_rep >= {16'd0, i_report_interval_ms});

        o_track.emit   = i_merge.act_any ? drive : lost_go;
        o_track.lost   = !i_merge.act_any;
        o_track.report = i_merge.act_any & rep;

        n_prev_main    = r_prev_main;
        n_stable_main  = r_stable_main;
        n_stable_count = r_stable_count;
        n_last_report  = r_last_report;
        n_last_signal  = r_last_signal;

        if (i_fire) begin
            if (!i_merge.act_any) begin
                if (lost_go) begin
                    n_prev_main    = NONE_SENSOR;
                    n_stable_main  = NONE_SENSOR;
                    n_stable_count = '0;
                end
            end else begin
                n_last_signal  = i_now;
                n_stable_count = cnt_next;
                n_prev_main    = i_merge.main_idx;
                if (drive) begin
                    n_stable_main = i_merge.main_idx;
                    if (rep) begin
                        n_last_report = i_now;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_main    <= NONE_SENSOR;
            r_stable_main  <= NONE_SENSOR;
            r_stable_count <= '0;
            r_last_report  <= '0;
            r_last_signal  <= '0;
        end else begin
            r_prev_main    <= n_prev_main;
            r_stable_main  <= n_stable_main;
            r_stable_count <= n_stable_count;
            r_last_report  <= n_last_report;
            r_last_signal  <= n_last_signal;
        end
    end

`ifndef ASSERT_OFF
    // A cleared count and an empty previous sensor always go together.
    a_count_vs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_main == NONE_SENSOR) == (r_stable_count == 8'd0))
        else $error("stable count and previous main sensor disagree");

    // A drive result can only be issued once the counter is nonzero.
    a_drive_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_track.emit && !o_track.lost) |=> (r_stable_count != 8'd0))
        else $error("drive result issued without a counted sensor");
`endif

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// IR bearing estimator testbench
// Streams sensor samples through the unit under several register settings and
// random handshake pacing. A predictor in the bench tracks the debounce and
// lost-signal state and checks every result beat, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    import irbe_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT     = 5_000_000;

    typedef struct {
        logic [5:0]  levels;
        logic [31:0] stamp;
    } t_reading;

    // Rounded bearing by [s1 + 2*s4][s0 - s5 + 1][s2 - s3 + 1], flattened.
    int heading_lut [0:35] = '{
        -141, 180, 141,  -90,   0,  90,  -39,   0,  39,
        -114, 105,  96,  -19,  30,  56,   -9,  15,  35,
        -104, -128, 128, -60, -30,  30,  -35, -13,  13,
         -51,  10,  58,  -24,   4,  30,  -15,   2,  19
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    irbe_in_if  sample_ch ();
    irbe_out_if result_ch ();

    ir_bearing_estimator_debounced_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // Register copies, kept in step with every write on the APB port.
    logic        cfg_active_level = RST_ACTIVE_LEVEL;
    logic [7:0]  cfg_stable_need  = RST_STABLE_THRESHOLD;
    logic [15:0] cfg_hold_ms      = RST_LOST_HOLD_MS;
    logic [15:0] cfg_report_ms    = RST_REPORT_INTERVAL;

    // Tracking state of the predictor.
    t_sensor     prev_lead      = NONE_SENSOR;
    t_sensor     stable_lead    = NONE_SENSOR;
    logic [7:0]  stable_cnt     = 8'd0;
    logic [31:0] last_report_ms = 32'd0;
    logic [31:0] last_signal_ms = 32'd0;

    t_reading pending_q [$];
    t_result  bearing_q [$];

    int          queued_cnt    = 0;
    int          accepted_cnt  = 0;
    int          fault_cnt     = 0;
    int          send_idle_pct = 13;
    int          recv_idle_pct = 81;
    logic [31:0] clock_ms      = 32'd1000;
    logic        took          = 1'b0;

    function automatic string fmt_result(input t_result r);
        return $sformatf("bearing=%0d lost=%0b main=%0d total=%0d report=%0b",
                         r.bearing_deg, r.lost, r.main_sensor, r.active_total, r.report);
    endfunction

    function automatic void note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // Advances the debounce state for one accepted sample; returns 1 when the
    // sample yields a result beat.
    function automatic bit predict_bearing(input logic [5:0] levels, input logic [31:0] stamp,
                                           output t_result r);
        logic [5:0] act;
        logic [5:0] kept;
        int         n;
        int         seen;
        int         row;
        int         nx;
        int         ny;
        t_sensor    lead;
        logic       rep;
        r    = '0;
        act  = cfg_active_level ? levels : ~levels;
        if (act == 6'd0) begin
            if (stamp - last_signal_ms > {16'd0, cfg_hold_ms}) begin
                stable_cnt    = 8'd0;
                prev_lead     = NONE_SENSOR;
                stable_lead   = NONE_SENSOR;
                r.bearing_deg = BEARING_LOST;
                r.lost        = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        kept = ((act & FRONT_MASK) != 6'd0) ? (act & FRONT_MASK) : act;
        n    = $countones(kept);
        seen = 0;
        lead = NONE_SENSOR;
        // The lead sensor is the median of the kept list, upper one on a tie.
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (kept[i]) begin
                if (seen == n / 2) begin
                    lead = t_sensor'(i);
                end
                seen++;
            end
        end
        row = int'(act[1]) + 2 * int'(act[4]);
        nx  = int'(act[0]) - int'(act[5]) + 1;
        ny  = int'(act[2]) - int'(act[3]) + 1;

        last_signal_ms = stamp;
        if (lead == prev_lead) begin
            if (stable_cnt != 8'hFF) begin
                stable_cnt = stable_cnt + 8'd1;
            end
        end else begin
            stable_cnt = 8'd1;
            prev_lead  = lead;
        end
        if (stable_cnt < cfg_stable_need) begin
            return 1'b0;
        end
        rep = (lead != stable_lead) || (stamp - last_report_ms >= {16'd0, cfg_report_ms});
        if (rep) begin
            last_report_ms = stamp;
        end
        stable_lead    = lead;
        r.bearing_deg  = t_deg'(heading_lut[row * 9 + nx * 3 + ny]);
        r.main_sensor  = lead;
        r.active_total = 3'(n);
        r.report       = rep;
        return 1'b1;
    endfunction

    // Input driver: a new beat is offered once the previous one was taken.
    always @(negedge i_clk) begin
        t_reading nxt;
        if (!sample_ch.valid || took) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                sample_ch.valid         <= 1'b1;
                sample_ch.sensor_levels <= nxt.levels;
                sample_ch.now_ms        <= nxt.stamp;
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: predicts on every input beat and checks every result beat.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        took <= sample_ch.valid && sample_ch.ready;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.bearing_deg  = result_ch.bearing_deg;
            got.lost         = result_ch.lost;
            got.main_sensor  = result_ch.main_sensor;
            got.active_total = result_ch.active_total;
            got.report       = result_ch.report;
            if (bearing_q.size() == 0) begin
                note_fault($sformatf("result with nothing expected: %s", fmt_result(got)));
            end else begin
                want = bearing_q.pop_front();
                if (got.bearing_deg !== want.bearing_deg || got.lost !== want.lost
                        || got.main_sensor !== want.main_sensor
                        || got.active_total !== want.active_total
                        || got.report !== want.report) begin
                    note_fault($sformatf("expected %s, got %s",
                                         fmt_result(want), fmt_result(got)));
                end
            end
        end
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            accepted_cnt++;
            if (predict_bearing(sample_ch.sensor_levels, sample_ch.now_ms, want)) begin
                bearing_q.push_back(want);
            end
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ACTIVE_LEVEL:     cfg_active_level = value[0];
            REG_STABLE_THRESHOLD: cfg_stable_need  = value[7:0];
            REG_LOST_HOLD_MS:     cfg_hold_ms      = value[15:0];
            REG_REPORT_INTERVAL:  cfg_report_ms    = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_all(input logic lvl, input logic [7:0] need,
                           input logic [15:0] hold, input logic [15:0] gap);
        cfg_write(REG_ACTIVE_LEVEL, {31'd0, lvl});
        cfg_write(REG_STABLE_THRESHOLD, {24'd0, need});
        cfg_write(REG_LOST_HOLD_MS, {16'd0, hold});
        cfg_write(REG_REPORT_INTERVAL, {16'd0, gap});
    endtask

    // Batches are queued just after a rising edge, clear of the driver.
    task automatic start_batch(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Queues one sample given as the set of sensors that should read active.
    task automatic push_sample(input logic [5:0] act, input int unsigned step_ms);
        t_reading rd;
        clock_ms  = clock_ms + step_ms;
        rd.levels = cfg_active_level ? act : ~act;
        rd.stamp  = clock_ms;
        pending_q.push_back(rd);
        queued_cnt++;
    endtask

    task automatic drain();
        do @(negedge i_clk); while (accepted_cnt != queued_cnt || bearing_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [5:0] pick_pattern();
        if ($urandom_range(0, 99) < 40) begin
            return 6'd1 << $urandom_range(0, 5);
        end
        return 6'($urandom_range(1, 63));
    endfunction

    // Mostly steady bursts that get past the debounce, mixed with silent
    // stretches around the hold time, noise and jumps of the clock.
    task automatic random_traffic(input int count);
        int         made;
        int         reps;
        int         burst_max;
        int         step_max;
        logic [5:0] pat;
        made      = 0;
        burst_max = (int'(cfg_stable_need) + 3 > 12) ? 12 : int'(cfg_stable_need) + 3;
        step_max  = int'(cfg_report_ms) / 3 + 4;
        while (made < count) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    pat  = pick_pattern();
                    reps = $urandom_range(1, burst_max);
                    for (int k = 0; k < reps; k++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            pat = pick_pattern();
                        end
                        push_sample(pat, $urandom_range(0, step_max));
                        made++;
                    end
                end
                11, 12, 13: begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_sample(6'd0, cfg_hold_ms);
                        push_sample(6'd0, 1);
                    end else begin
                        reps = $urandom_range(1, 4);
                        for (int k = 0; k < reps; k++) begin
                            push_sample(6'd0, $urandom_range(0, 2 * int'(cfg_hold_ms) + 2));
                        end
                    end
                end
                14, 15, 16, 17, 18: begin
                    push_sample(6'($urandom_range(0, 63)), $urandom_range(0, 400));
                    made++;
                end
                default: begin
                    clock_ms = $urandom();
                    push_sample(pick_pattern(), 0);
                    made++;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.sensor_levels = '0;
        sample_ch.now_ms        = '0;
        result_ch.ready         = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset settings.
        start_batch(13, 81);
        push_sample(6'b100001, 0);     // sensors 0 and 5 cancel out
        push_sample(6'b100001, 5);
        push_sample(6'b100000, 5);     // sensor 5 alone reads +180
        push_sample(6'b100000, 5);
        for (int k = 0; k < 5; k++) begin
            push_sample(6'd1 << k, 5);
            push_sample(6'd1 << k, 5);
        end
        push_sample(6'b111111, 5);
        push_sample(6'b111111, 5);
        push_sample(6'd0, 120);        // exactly at the hold time: no result
        push_sample(6'd0, 1);          // one past it: lost
        clock_ms = 32'hFFFF_FFF0;
        push_sample(6'b001100, 0);     // sensors 2 and 3 cancel out
        push_sample(6'b001100, 32'h15); // across the wrap of the clock
        push_sample(6'd0, 32'h5B);
        push_sample(6'd0, 32'hA0);
        drain();

        set_all(1'b1, 8'd1, 16'd0, 16'd0);
        start_batch(13, 81);
        random_traffic(160);
        drain();

        // The highest threshold needs long steady runs; this one also
        // pushes the stability counter into saturation.
        set_all(1'b0, 8'd255, 16'hFFFF, 16'hFFFF);
        start_batch(81, 13);
        for (int k = 0; k < 300; k++) begin
            push_sample(6'b000100, $urandom_range(1, 3));
        end
        random_traffic(40);
        drain();

        set_all(1'b1, 8'd3, 16'd50, 16'd100);
        start_batch(81, 13);
        random_traffic(160);
        drain();

        set_all(1'b0, 8'd2, 16'd200, 16'd20);
        start_batch(0, 0);
        random_traffic(160);
        drain();

        if (bearing_q.size() != 0) begin
            note_fault($sformatf("%0d expected results never arrived", bearing_q.size()));
        end
        if (fault_cnt == 0) begin
            $display("** ir_bearing_estimator_debounced_unit: PASSED **");
        end else begin
            $display("** ir_bearing_estimator_debounced_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("ERROR: run did not finish in time");
        $display("** ir_bearing_estimator_debounced_unit: FAILED **");
        $finish;
    end

endmodule
